// File: src/assert_macros.svh
// assertion macros used by the point grouper back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on the rising clock edge outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/knpg_pkg.sv
// shared types, codes and constants of the k-nearest point grouper
`timescale 1ns / 1ps

package knpg_pkg;

   // default sizes
   localparam int DEF_MAX_POINTS = 1024;
   localparam int DEF_GROUP_SIZE = 4;
   localparam int RESULT_CAP     = 4;
   localparam int QUEUE_DEPTH    = 4;

   // field widths
   localparam int MODE_W   = 2;
   localparam int COORD_W  = 20;
   localparam int INDEX_W  = 10;
   localparam int RANK_W   = 2;
   localparam int STATUS_W = 2;
   localparam int MAG_W    = COORD_W;
   localparam int SQ_W     = 2 * MAG_W;
   localparam int DIST_W   = SQ_W + 1;

   // item modes
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FEW   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

   // back-end command codes
   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
   localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

   // control part of a queued command
   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [STATUS_W-1:0] status;
   } knpg_cmd_type;

endpackage

// File: src/k_nearest_point_grouper.sv
// top level of the k-nearest point grouper
`timescale 1ns / 1ps

// Items enter on start while busy is low; busy is high only while the
// four-entry command queue is full. Clear takes effect at once and gives no
// result; an append is written to the point memory at the end of the cycle
// in which it leaves the queue. A query holds the back end while it fetches
// the query point, reads one stored point per cycle through the single read
// port of the point memory, passes the points through four pipeline stages
// for distance and list update, and waits until the pipeline is empty.
// It then emits min(GROUP_SIZE, 4) results on consecutive cycles, after
// which the back end is free again. Errors and a full store give one
// result, on the cycle after the item leaves the queue. Results appear on
// rsp_valid for one cycle each and cannot be held off.

module k_nearest_point_grouper
   import knpg_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS,
   parameter int GROUP_SIZE = DEF_GROUP_SIZE
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [MODE_W-1:0]         req_mode,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   input  logic [INDEX_W-1:0]        req_query_index,
   output logic                      rsp_valid,
   output logic [INDEX_W-1:0]        rsp_neighbour_index,
   output logic [RANK_W-1:0]         rsp_rank,
   output logic                      rsp_last,
   output logic [STATUS_W-1:0]       rsp_status
);

   localparam int AW     = $clog2(MAX_POINTS);
   localparam int CW     = $clog2(MAX_POINTS + 1);
   localparam int DATA_W = $bits(knpg_cmd_type) + AW + CW + 2 * COORD_W;

   logic                      queue_full;
   logic                      cmd_push;
   knpg_cmd_type              f_cmd;
   logic [AW-1:0]             f_addr;
   logic [CW-1:0]             f_len;
   logic signed [COORD_W-1:0] f_x;
   logic signed [COORD_W-1:0] f_y;
   logic [DATA_W-1:0]         push_data;
   logic [DATA_W-1:0]         head_data;
   logic                      head_valid;
   logic                      cmd_pop;
   knpg_cmd_type              b_cmd;
   logic [AW-1:0]             b_addr;
   logic [CW-1:0]             b_len;
   logic signed [COORD_W-1:0] b_x;
   logic signed [COORD_W-1:0] b_y;

   // front end
   knpg_front #(
      .MAX_POINTS (MAX_POINTS),
      .GROUP_SIZE (GROUP_SIZE)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_query_index (req_query_index),
      .queue_full      (queue_full),
      .cmd_push        (cmd_push),
      .cmd             (f_cmd),
      .cmd_addr        (f_addr),
      .cmd_len         (f_len),
      .cmd_x           (f_x),
      .cmd_y           (f_y)
   );

   // command queue
   assign push_data = {f_cmd, f_addr, f_len, f_x, f_y};

   knpg_cmd_queue #(
      .DATA_W (DATA_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (push_data),
      .pop       (cmd_pop),
      .head_data (head_data),
      .not_empty (head_valid),
      .full      (queue_full)
   );

   assign {b_cmd, b_addr, b_len, b_x, b_y} = head_data;

   // back end
   knpg_back #(
      .MAX_POINTS (MAX_POINTS),
      .GROUP_SIZE (GROUP_SIZE)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .cmd_valid           (head_valid),
      .cmd                 (b_cmd),
      .cmd_addr            (b_addr),
      .cmd_len             (b_len),
      .cmd_x               (b_x),
      .cmd_y               (b_y),
      .cmd_pop             (cmd_pop),
      .rsp_valid           (rsp_valid),
      .rsp_neighbour_index (rsp_neighbour_index),
      .rsp_rank            (rsp_rank),
      .rsp_last            (rsp_last),
      .rsp_status          (rsp_status)
   );

endmodule

// File: src/knpg_front.sv
// front end: takes items, keeps the point count, turns items into commands
`timescale 1ns / 1ps

module knpg_front
   import knpg_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS,
   parameter int GROUP_SIZE = DEF_GROUP_SIZE
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [MODE_W-1:0]         req_mode,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   input  logic [INDEX_W-1:0]        req_query_index,
   input  logic                      queue_full,
   output logic                      cmd_push,
   output knpg_cmd_type              cmd,
   output logic [$clog2(MAX_POINTS)-1:0]   cmd_addr,
   output logic [$clog2(MAX_POINTS+1)-1:0] cmd_len,
   output logic signed [COORD_W-1:0] cmd_x,
   output logic signed [COORD_W-1:0] cmd_y
);

   localparam int AW    = $clog2(MAX_POINTS);
   localparam int CW    = $clog2(MAX_POINTS + 1);
   localparam int K_EFF = (GROUP_SIZE < RESULT_CAP) ? GROUP_SIZE : RESULT_CAP;
   localparam int CMP_W = (CW > INDEX_W) ? CW : INDEX_W;

   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;
   logic             accept;
   logic [CMP_W-1:0] q_ext;
   logic [CMP_W-1:0] cnt_ext;

   assign busy   = queue_full;
   assign accept = start && !queue_full;
   assign q_ext   = CMP_W'(req_query_index);
   assign cnt_ext = CMP_W'(count_ff);
   assign cmd_x   = req_point_x;
   assign cmd_y   = req_point_y;

   // classify the accepted beat and track the count
   always_comb begin
      count_in   = count_ff;
      cmd_push   = 1'b0;
      cmd.op     = OP_WRITE;
      cmd.status = ST_OK;
      cmd_addr   = count_ff[AW-1:0];
      cmd_len    = count_ff;
      if (accept) begin
         unique case (req_mode)
            MODE_CLEAR: begin
               count_in = '0;
            end
            MODE_APPEND: begin
               cmd_push = 1'b1;
               if (count_ff == CW'(MAX_POINTS)) begin
                  cmd.op     = OP_REPORT;
                  cmd.status = ST_FULL;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            MODE_QUERY: begin
               cmd_push = 1'b1;
               if (q_ext >= cnt_ext) begin
                  cmd.op     = OP_REPORT;
                  cmd.status = ST_RANGE;
               end else if (count_ff < CW'(K_EFF)) begin
                  cmd.op     = OP_REPORT;
                  cmd.status = ST_FEW;
               end else begin
                  cmd.op   = OP_QUERY;
                  cmd_addr = q_ext[AW-1:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // point count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// File: src/knpg_cmd_queue.sv
// short command queue between front end and back end
`timescale 1ns / 1ps

module knpg_cmd_queue
   import knpg_pkg::*;
#(
   parameter int DATA_W = 8,
   parameter int DEPTH  = QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] head_data,
   output logic              not_empty,
   output logic              full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff;
   logic [PW-1:0]     wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff;
   logic [PW-1:0]     rd_ptr_in;
   logic [NW-1:0]     fill_ff;
   logic [NW-1:0]     fill_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (fill_ff == NW'(DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head_data = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/knpg_back.sv
// back end: point memory, distance scan with running top-k list, results
`timescale 1ns / 1ps

module knpg_back
   import knpg_pkg::*;
#(
   parameter int MAX_POINTS = DEF_MAX_POINTS,
   parameter int GROUP_SIZE = DEF_GROUP_SIZE
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   input  knpg_cmd_type              cmd,
   input  logic [$clog2(MAX_POINTS)-1:0]   cmd_addr,
   input  logic [$clog2(MAX_POINTS+1)-1:0] cmd_len,
   input  logic signed [COORD_W-1:0] cmd_x,
   input  logic signed [COORD_W-1:0] cmd_y,
   output logic                      cmd_pop,
   output logic                      rsp_valid,
   output logic [INDEX_W-1:0]        rsp_neighbour_index,
   output logic [RANK_W-1:0]         rsp_rank,
   output logic                      rsp_last,
   output logic [STATUS_W-1:0]       rsp_status
);

`include "assert_macros.svh"

   localparam int AW    = $clog2(MAX_POINTS);
   localparam int CW    = $clog2(MAX_POINTS + 1);
   localparam int K_EFF = (GROUP_SIZE < RESULT_CAP) ? GROUP_SIZE : RESULT_CAP;
   localparam int QW    = (AW > INDEX_W) ? AW : INDEX_W;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_LOADQ = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   // point memory, x in the upper half
   logic [2*COORD_W-1:0] point_mem [MAX_POINTS];
   logic [2*COORD_W-1:0] rd_data_ff;
   logic [AW-1:0]        rd_addr;
   logic                 mem_we;

   // sequencer
   logic [1:0]  state_ff;
   logic [1:0]  state_in;
   logic [CW-1:0] scan_ff;
   logic [CW-1:0] scan_in;
   logic [CW-1:0] len_ff;
   logic [CW-1:0] len_in;
   logic [RANK_W-1:0] rank_ff;
   logic [RANK_W-1:0] rank_in;
   logic        issue;
   logic        pipe_busy;
   logic        emit_last;

   // query point
   logic signed [COORD_W-1:0] qx_ff;
   logic signed [COORD_W-1:0] qy_ff;

   // distance pipeline
   logic              v1_ff, v2_ff, v3_ff, v4_ff;
   logic [AW-1:0]     idx1_ff, idx2_ff, idx3_ff, idx4_ff;
   logic [MAG_W-1:0]  magx2_ff, magy2_ff;
   logic [SQ_W-1:0]   sqx3_ff, sqy3_ff;
   logic [DIST_W-1:0] dist4_ff;
   logic signed [COORD_W:0] dx;
   logic signed [COORD_W:0] dy;
   logic [COORD_W:0]  absx;
   logic [COORD_W:0]  absy;

   // running nearest list, sorted, nearest at slot 0
   logic [DIST_W-1:0] best_d_ff [K_EFF];
   logic [DIST_W-1:0] best_d_in [K_EFF];
   logic [AW-1:0]     best_i_ff [K_EFF];
   logic [AW-1:0]     best_i_in [K_EFF];
   logic [K_EFF-1:0]  best_v_ff;
   logic [K_EFF-1:0]  best_v_in;
   logic [K_EFF-1:0]  keep;

   // result registers
   logic              rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [RANK_W-1:0] rsp_rank_ff, rsp_rank_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [QW-1:0]     head_ext;

   assign pipe_busy = v1_ff || v2_ff || v3_ff || v4_ff;
   assign issue     = (state_ff == S_SCAN) && (scan_ff != len_ff);
   assign emit_last = (rank_ff == RANK_W'(K_EFF - 1));
   assign head_ext  = QW'(best_i_ff[0]);

   // command dispatch and scan sequencing
   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      len_in        = len_ff;
      rank_in       = rank_ff;
      cmd_pop       = 1'b0;
      mem_we        = 1'b0;
      rd_addr       = cmd_addr;
      rsp_valid_in  = 1'b0;
      rsp_idx_in    = rsp_idx_ff;
      rsp_rank_in   = rsp_rank_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               unique case (cmd.op)
                  OP_WRITE: begin
                     mem_we = 1'b1;
                  end
                  OP_REPORT: begin
                     rsp_valid_in  = 1'b1;
                     rsp_idx_in    = '0;
                     rsp_rank_in   = '0;
                     rsp_last_in   = 1'b1;
                     rsp_status_in = cmd.status;
                  end
                  OP_QUERY: begin
                     len_in   = cmd_len;
                     state_in = S_LOADQ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LOADQ: begin
            scan_in  = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            rd_addr = scan_ff[AW-1:0];
            if (issue) begin
               scan_in = scan_ff + 1'b1;
            end else if (!pipe_busy) begin
               rank_in  = '0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            rsp_valid_in  = 1'b1;
            rsp_idx_in    = head_ext[INDEX_W-1:0];
            rsp_rank_in   = rank_ff;
            rsp_last_in   = emit_last;
            rsp_status_in = ST_OK;
            rank_in       = rank_ff + 1'b1;
            if (emit_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // signed differences to the query point
   always_comb begin
      dx   = $signed({rd_data_ff[2*COORD_W-1], rd_data_ff[2*COORD_W-1:COORD_W]})
             - $signed({qx_ff[COORD_W-1], qx_ff});
      dy   = $signed({rd_data_ff[COORD_W-1], rd_data_ff[COORD_W-1:0]})
             - $signed({qy_ff[COORD_W-1], qy_ff});
      absx = dx[COORD_W] ? COORD_W'(0) - dx : dx;
      absy = dy[COORD_W] ? COORD_W'(0) - dy : dy;
   end

   // insert into the sorted list, ties keep the earlier (lower) index first;
   // on emit the list shifts one slot toward the head
   always_comb begin
      logic prev_keep;
      int   src;
      prev_keep = 1'b1;
      src       = 0;
      best_v_in = best_v_ff;
      for (int i = 0; i < K_EFF; i++) begin
         best_d_in[i] = best_d_ff[i];
         best_i_in[i] = best_i_ff[i];
         keep[i]      = best_v_ff[i] && (best_d_ff[i] <= dist4_ff);
      end
      if (state_ff == S_LOADQ) begin
         best_v_in = '0;
      end else if (state_ff == S_EMIT) begin
         for (int i = 0; i < K_EFF - 1; i++) begin
            best_i_in[i] = best_i_ff[i + 1];
         end
      end else if (v4_ff) begin
         for (int i = 0; i < K_EFF; i++) begin
            src = (i > 0) ? i - 1 : 0;
            if (!keep[i]) begin
               if (prev_keep) begin
                  best_d_in[i] = dist4_ff;
                  best_i_in[i] = idx4_ff;
                  best_v_in[i] = 1'b1;
               end else begin
                  best_d_in[i] = best_d_ff[src];
                  best_i_in[i] = best_i_ff[src];
                  best_v_in[i] = best_v_ff[src];
               end
            end
            prev_keep = keep[i];
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         best_v_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         v1_ff        <= issue;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         best_v_ff    <= best_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      len_ff        <= len_in;
      rank_ff       <= rank_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_rank_ff   <= rsp_rank_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      if (state_ff == S_LOADQ) begin
         qx_ff <= rd_data_ff[2*COORD_W-1:COORD_W];
         qy_ff <= rd_data_ff[COORD_W-1:0];
      end
      idx1_ff  <= scan_ff[AW-1:0];
      idx2_ff  <= idx1_ff;
      magx2_ff <= absx[MAG_W-1:0];
      magy2_ff <= absy[MAG_W-1:0];
      idx3_ff  <= idx2_ff;
      sqx3_ff  <= magx2_ff * magx2_ff;
      sqy3_ff  <= magy2_ff * magy2_ff;
      idx4_ff  <= idx3_ff;
      dist4_ff <= {1'b0, sqx3_ff} + {1'b0, sqy3_ff};
      for (int i = 0; i < K_EFF; i++) begin
         best_d_ff[i] <= best_d_in[i];
         best_i_ff[i] <= best_i_in[i];
      end
   end

   // point memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         point_mem[cmd_addr] <= {cmd_x, cmd_y};
      end
      rd_data_ff <= point_mem[rd_addr];
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_neighbour_index = rsp_idx_ff;
   assign rsp_rank            = rsp_rank_ff;
   assign rsp_last            = rsp_last_ff;
   assign rsp_status          = rsp_status_ff;

   // checks
   `ASSERT_NEXT(a_rank_steps, rsp_valid_ff && !rsp_last_ff,
      rsp_valid_ff && (rsp_rank_ff == $past(rsp_rank_ff) + 2'd1), "rank did not step")
   `ASSERT_IMPLY(a_error_single, rsp_valid_ff && (rsp_status_ff != ST_OK),
      rsp_last_ff && (rsp_rank_ff == '0), "error result not single")
   `ASSERT_IMPLY(a_scan_bound, state_ff == S_SCAN, scan_ff <= len_ff, "scan past count")
   `ASSERT_IMPLY(a_list_full, (state_ff == S_EMIT) && (rank_ff == '0),
      &best_v_ff, "nearest list not full at emit")

endmodule
